// ----- sv/itp_pkg.sv -----
// Shared types and constants of the isometric tile picker.
// Depends on nothing; every other file of the block uses it by scoped names.
package itp_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'd1;

    // Largest distance a point can lie left of or above the origin.
    localparam int ORIGIN_SPAN = 32767;

    // Width of a biased, always non-negative offset from the origin.
    localparam int OFS_W = 17;

    // Signed width of tile indices; holds the widest grid plus one step off it.
    localparam int IDX_W = 10;

    // Corner codes of a result.
    localparam logic [2:0] CORNER_NONE = 3'd0;
    localparam logic [2:0] CORNER_LT   = 3'd1;
    localparam logic [2:0] CORNER_RT   = 3'd2;
    localparam logic [2:0] CORNER_LB   = 3'd3;
    localparam logic [2:0] CORNER_RB   = 3'd4;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [11:0] point_x;
        logic [11:0] point_y;
    } pick_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] tile_col;
        logic [3:0] tile_row;
        logic [2:0] corner;
    } result_t;

    typedef struct packed {
        logic [OFS_W-1:0] ofs_x;
        logic [OFS_W-1:0] ofs_y;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- sv/itp_if.sv -----
// Stream interfaces of the isometric tile picker: point input and result output.
// Depends on itp_pkg for the payload types.
interface itp_pick_if;
    logic          valid;
    logic          ready;
    itp_pkg::pick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface itp_result_if;
    logic             valid;
    logic             ready;
    itp_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/itp_front.sv -----
// Front of the isometric tile picker: origin registers and point intake.
// Depends on itp_pkg and itp_if; feeds itp_queue.
module itp_front #(
    parameter int CELL_W = 64,
    parameter int CELL_H = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data,
    itp_pick_if.sink                       pick,
    input  itp_pkg::queue_stat_t           stat,
    output logic                           push,
    output itp_pkg::queue_entry_t          entry
);
    localparam int UW     = itp_pkg::OFS_W;
    localparam int SW     = UW + 1;
    localparam int KX     = (itp_pkg::ORIGIN_SPAN + CELL_W - 1) / CELL_W;
    localparam int KY     = (itp_pkg::ORIGIN_SPAN + CELL_H - 1) / CELL_H;
    localparam int BIAS_X = KX * CELL_W;
    localparam int BIAS_Y = KY * CELL_H;

    logic signed [itp_pkg::CFG_DATA_W-1:0] origin_x_reg, origin_x_next;
    logic signed [itp_pkg::CFG_DATA_W-1:0] origin_y_reg, origin_y_next;
    logic signed [SW-1:0]                  sum_x, sum_y;

    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                itp_pkg::CFG_ORIGIN_X: origin_x_next = cfg_data;
                itp_pkg::CFG_ORIGIN_Y: origin_y_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    // The bias is a whole number of cells, so the offset stays non-negative
    // and the back can floor it with an unsigned division.
    always_comb
    begin
        sum_x = $signed(SW'(pick.data.point_x)) - SW'(origin_x_reg) + $signed(SW'(BIAS_X));
        sum_y = $signed(SW'(pick.data.point_y)) - SW'(origin_y_reg) + $signed(SW'(BIAS_Y));
        entry.ofs_x = sum_x[UW-1:0];
        entry.ofs_y = sum_y[UW-1:0];
    end

    assign pick.ready = !stat.full;
    assign push       = pick.valid && !stat.full;

endmodule

// ----- sv/itp_queue.sv -----
// Short queue that decouples the front from the back of the tile picker.
// Depends on itp_pkg for the entry and status types.
module itp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  itp_pkg::queue_entry_t wr_entry,
    input  logic                  pop,
    output itp_pkg::queue_entry_t rd_entry,
    output itp_pkg::queue_stat_t  stat
);
    localparam int DEPTH = itp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itp_pkg::queue_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- sv/itp_back.sv -----
// Back of the isometric tile picker: cell floor, edge test, neighbor move, result.
// Depends on itp_pkg and itp_if; drains itp_queue.
module itp_back #(
    parameter int TILES_ACROSS = 16,
    parameter int TILES_DOWN   = 16,
    parameter int CELL_W       = 64,
    parameter int CELL_H       = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  itp_pkg::queue_entry_t rd_entry,
    input  itp_pkg::queue_stat_t  stat,
    output logic                  pop,
    itp_result_if.source          result
);
    localparam int UW  = itp_pkg::OFS_W;
    localparam int CXW = UW + 1;
    localparam int CLW = CXW + 1;
    localparam int TW  = itp_pkg::IDX_W;
    localparam int KX  = (itp_pkg::ORIGIN_SPAN + CELL_W - 1) / CELL_W;
    localparam int KY  = (itp_pkg::ORIGIN_SPAN + CELL_H - 1) / CELL_H;
    // Reciprocals exact for every UW-bit dividend.
    localparam int SX  = UW + $clog2(CELL_W);
    localparam int SY  = UW + $clog2(CELL_H);
    localparam int MX  = (2**SX + CELL_W - 1) / CELL_W;
    localparam int MY  = (2**SY + CELL_H - 1) / CELL_H;
    localparam int MW  = UW + 2;
    localparam int PRW = UW + MW;
    localparam int PXW = $clog2(CELL_W);
    localparam int PYW = $clog2(CELL_H);
    localparam int PW  = PXW + PYW + 4;
    localparam int RW  = CELL_W / 2;
    localparam int RH  = CELL_H / 2;

    logic en;

    // Stage 1: quotients.
    logic              v1_reg, v1_next;
    logic [UW-1:0]     s1_ux_reg, s1_uy_reg, s1_qx_reg, s1_qy_reg;
    logic [UW-1:0]     s1_qx_next, s1_qy_next;
    logic [PRW-1:0]    prod_x, prod_y;

    // Stage 2: offsets within the cell and the cell's tile.
    logic              v2_reg, v2_next;
    logic [PXW-1:0]    s2_px_reg, s2_px_next;
    logic [PYW-1:0]    s2_py_reg, s2_py_next;
    logic signed [TW-1:0] s2_col_reg, s2_col_next, s2_row_reg, s2_row_next;
    logic              s2_ok_reg, s2_ok_next;
    logic signed [CXW-1:0] cx, cy;
    logic signed [CLW-1:0] col_full, row_full;

    // Stage 3: edge test operands.
    logic              v3_reg, v3_next;
    logic signed [PW-1:0] s3_lhs_reg, s3_lhs_next, s3_rhs_reg, s3_rhs_next;
    logic [2:0]        s3_corner_reg, s3_corner_next;
    logic signed [TW-1:0] s3_col_reg, s3_row_reg;
    logic              s3_ok_reg;
    logic signed [PW-1:0] pxs, pys, rws, rhs;
    logic              left, top;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    itp_pkg::result_t  res_reg, res_next;
    logic signed [TW-1:0] mcol, mrow;
    logic              in_edge, in_grid;

    assign en  = !res_valid_reg || result.ready;
    assign pop = en && !stat.empty;

    assign v1_next        = pop;
    assign v2_next        = v1_reg;
    assign v3_next        = v2_reg;
    assign res_valid_next = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Stage 1: floor by a constant through a reciprocal multiply.
    always_comb
    begin
        prod_x     = PRW'(rd_entry.ofs_x) * PRW'(MX);
        prod_y     = PRW'(rd_entry.ofs_y) * PRW'(MY);
        s1_qx_next = UW'(prod_x >> SX);
        s1_qy_next = UW'(prod_y >> SY);
    end

    // Stage 2: remainder and the tile that owns the cell's diamond.
    always_comb
    begin
        s2_px_next  = PXW'(s1_ux_reg - UW'(s1_qx_reg * UW'(CELL_W)));
        s2_py_next  = PYW'(s1_uy_reg - UW'(s1_qy_reg * UW'(CELL_H)));
        cx          = $signed({1'b0, s1_qx_reg}) - $signed(CXW'(KX));
        cy          = $signed({1'b0, s1_qy_reg}) - $signed(CXW'(KY));
        col_full    = {cx[CXW-1], cx} + {cy[CXW-1], cy};
        row_full    = {cy[CXW-1], cy} - {cx[CXW-1], cx};
        s2_ok_next  = (col_full >= 0) && (col_full < $signed(CLW'(TILES_ACROSS)))
                   && (row_full >= 0) && (row_full < $signed(CLW'(TILES_DOWN)));
        s2_col_next = TW'(col_full);
        s2_row_next = TW'(row_full);
    end

    // Stage 3: quadrant and the two sides of its edge, all as lhs <= rhs.
    always_comb
    begin
        pxs  = PW'(s2_px_reg);
        pys  = PW'(s2_py_reg);
        rws  = PW'(RW);
        rhs  = PW'(RH);
        left = ({1'b0, s2_px_reg, 1'b0} < (PXW + 2)'(CELL_W));
        top  = ({1'b0, s2_py_reg, 1'b0} < (PYW + 2)'(CELL_H));
        case ({left, top})
            2'b11:
            begin
                s3_corner_next = itp_pkg::CORNER_LT;
                s3_lhs_next    = rws * (rhs - pys);
                s3_rhs_next    = pxs * rhs;
            end
            2'b01:
            begin
                s3_corner_next = itp_pkg::CORNER_RT;
                s3_lhs_next    = (pxs - rws) * rhs;
                s3_rhs_next    = pys * rws;
            end
            2'b10:
            begin
                s3_corner_next = itp_pkg::CORNER_LB;
                s3_lhs_next    = (pys - rhs) * rws;
                s3_rhs_next    = pxs * rhs;
            end
            default:
            begin
                s3_corner_next = itp_pkg::CORNER_RB;
                s3_lhs_next    = (pxs - rws) * rhs;
                s3_rhs_next    = rws * (rhs + rhs - pys);
            end
        endcase
    end

    // Output: move to the neighbor when outside the edge, then check the grid.
    always_comb
    begin
        in_edge = (s3_lhs_reg <= s3_rhs_reg);
        mcol    = s3_col_reg;
        mrow    = s3_row_reg;
        if (!in_edge)
        begin
            case (s3_corner_reg)
                itp_pkg::CORNER_LT: mcol = s3_col_reg - TW'(1);
                itp_pkg::CORNER_RT: mrow = s3_row_reg - TW'(1);
                itp_pkg::CORNER_LB: mrow = s3_row_reg + TW'(1);
                default:            mcol = s3_col_reg + TW'(1);
            endcase
        end
        in_grid = s3_ok_reg
               && (mcol >= 0) && (mcol < $signed(TW'(TILES_ACROSS)))
               && (mrow >= 0) && (mrow < $signed(TW'(TILES_DOWN)));
        res_next.hit      = in_grid;
        res_next.tile_col = in_grid ? mcol[3:0] : 4'd0;
        res_next.tile_row = in_grid ? mrow[3:0] : 4'd0;
        res_next.corner   = (in_grid && !in_edge) ? s3_corner_reg : itp_pkg::CORNER_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ux_reg     <= rd_entry.ofs_x;
            s1_uy_reg     <= rd_entry.ofs_y;
            s1_qx_reg     <= s1_qx_next;
            s1_qy_reg     <= s1_qy_next;
            s2_px_reg     <= s2_px_next;
            s2_py_reg     <= s2_py_next;
            s2_col_reg    <= s2_col_next;
            s2_row_reg    <= s2_row_next;
            s2_ok_reg     <= s2_ok_next;
            s3_lhs_reg    <= s3_lhs_next;
            s3_rhs_reg    <= s3_rhs_next;
            s3_corner_reg <= s3_corner_next;
            s3_col_reg    <= s2_col_reg;
            s3_row_reg    <= s2_row_reg;
            s3_ok_reg     <= s2_ok_reg;
            res_reg       <= res_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

// ----- sv/iso_tile_pick_top.sv -----
// Top level of the isometric tile picker: front, queue and back wired together.
// Depends on itp_pkg, itp_if, itp_front, itp_queue and itp_back.

// The picker maps one screen point to a tile of an isometric diamond grid and
// sustains one point per clock cycle: a new point transfer can be taken in
// every cycle while results keep being taken. A point is written into the
// queue at its transfer edge, then passes through the back's three pipeline
// stages, each ending in a register: the reciprocal multiply that floors the
// offset into a cell, the multiply back to the cell remainder and the edge
// cross-multiplications. Its result is then held in the back's output
// register. The origin registers are written through the plain write port
// and should only change while no point is in flight. A stall on the result
// side freezes the back pipeline; the two-entry queue keeps the input side
// accepting until it fills.
module iso_tile_pick_top #(
    parameter int TILES_ACROSS = 16,
    parameter int TILES_DOWN   = 16,
    parameter int CELL_W       = 64,
    parameter int CELL_H       = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data,
    itp_pick_if.sink                       pick,
    itp_result_if.source                   result
);
    // Queue handshake between the front and the back.
    itp_pkg::queue_stat_t  stat;
    itp_pkg::queue_entry_t wr_entry;
    itp_pkg::queue_entry_t rd_entry;
    logic                  push;
    logic                  pop;

    // The front holds the origin and turns each point into a biased offset.
    itp_front #(
        .CELL_W (CELL_W),
        .CELL_H (CELL_H)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pick      (pick),
        .stat      (stat),
        .push      (push),
        .entry     (wr_entry)
    );

    itp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .stat     (stat)
    );

    // The back floors into a cell, tests the diamond edge and builds the result.
    itp_back #(
        .TILES_ACROSS (TILES_ACROSS),
        .TILES_DOWN   (TILES_DOWN),
        .CELL_W       (CELL_W),
        .CELL_H       (CELL_H)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_entry (rd_entry),
        .stat     (stat),
        .pop      (pop),
        .result   (result)
    );

    // A miss carries no tile and no corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.hit) |->
        (result.data.tile_col == 4'd0 && result.data.tile_row == 4'd0
         && result.data.corner == itp_pkg::CORNER_NONE))
        else $error("miss result carries tile or corner data");

    // The corner code never goes past the last cell corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.corner <= itp_pkg::CORNER_RB))
        else $error("corner code out of range");

    // The queue is never reported full and empty at once, and never pops empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty) && !(pop && stat.empty))
        else $error("queue status inconsistent");

endmodule

// ----- dv/iso_tile_pick_top_tb.sv -----
// Self-checking testbench of the isometric tile picker top level.
// Depends on itp_pkg and itp_if, and on iso_tile_pick_top with its submodules.
module iso_tile_pick_top_tb;

    // Grid geometry. The same values are handed to the block so that both sides agree.
    localparam int TILES_ACROSS = 16;
    localparam int TILES_DOWN   = 16;
    localparam int CELL_W       = 64;
    localparam int CELL_H       = 32;
    localparam int HALF_W       = CELL_W / 2;
    localparam int HALF_H       = CELL_H / 2;

    // Origin used by the directed points, chosen so the whole grid is on screen.
    localparam int DIR_OX = 1024;
    localparam int DIR_OY = 64;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [itp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [itp_pkg::CFG_DATA_W-1:0] cfg_data;

    itp_pick_if   pick_ch ();
    itp_result_if res_ch ();

    iso_tile_pick_top #(
        .TILES_ACROSS (TILES_ACROSS),
        .TILES_DOWN   (TILES_DOWN),
        .CELL_W       (CELL_W),
        .CELL_H       (CELL_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pick      (pick_ch),
        .result    (res_ch)
    );

    // Our own copy of the origin registers, updated when a write is issued.
    // Writes only happen while no point is in flight, so this is exact.
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;

    itp_pkg::pick_t   point_feed[$];    // points waiting to be presented
    itp_pkg::result_t tile_expect[$];   // predicted results, oldest first

    int  send_gap;
    int  take_stall;
    bit  jitter_on;            // when clear, neither side inserts gaps
    int  error_count;
    int  points_sent;
    int  results_seen;
    int  hit_count;
    int  moved_count;
    int  origin_count;

    // Clock: period of 10 time units.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. The slowest legal run is well below a fifth of this.
    initial
    begin
        #10000000;
        $display("iso_tile_pick_top_tb failed");
        $finish;
    end

    function automatic bit off_grid(input int col, input int row);
        return col < 0 || col >= TILES_ACROSS || row < 0 || row >= TILES_DOWN;
    endfunction

    // Works out which tile a screen point lands on for the given origin.
    // The offset is floored into a cell, the cell gives a tile, and the point
    // is then tested against the diamond edge of its quadrant. All integer.
    function automatic itp_pkg::result_t predict_tile(input itp_pkg::pick_t pt,
                                                      input int org_x,
                                                      input int org_y);
        int               ofs_x;
        int               ofs_y;
        int               cell_x;
        int               cell_y;
        int               col;
        int               row;
        int               in_x;
        int               in_y;
        logic [2:0]       side;
        bit               in_diamond;
        itp_pkg::result_t res;

        res   = '0;
        ofs_x = int'(pt.point_x) - org_x;
        ofs_y = int'(pt.point_y) - org_y;
        // Floor toward minus infinity on both axes.
        cell_x = (ofs_x >= 0) ? ofs_x / CELL_W : -((-ofs_x + CELL_W - 1) / CELL_W);
        cell_y = (ofs_y >= 0) ? ofs_y / CELL_H : -((-ofs_y + CELL_H - 1) / CELL_H);
        col    = cell_x + cell_y;
        row    = cell_y - cell_x;
        in_x   = ofs_x - cell_x * CELL_W;
        in_y   = ofs_y - cell_y * CELL_H;

        if (off_grid(col, row))
            return res;

        if (2 * in_x < CELL_W)
            side = (2 * in_y < CELL_H) ? itp_pkg::CORNER_LT : itp_pkg::CORNER_LB;
        else
            side = (2 * in_y < CELL_H) ? itp_pkg::CORNER_RT : itp_pkg::CORNER_RB;

        case (side)
            itp_pkg::CORNER_LT: in_diamond = HALF_W * (HALF_H - in_y) <= in_x * HALF_H;
            itp_pkg::CORNER_RT: in_diamond = in_y * HALF_W >= (in_x - HALF_W) * HALF_H;
            itp_pkg::CORNER_LB: in_diamond = (in_y - HALF_H) * HALF_W <= in_x * HALF_H;
            default:            in_diamond = HALF_W * (HALF_H - (in_y - HALF_H))
                                             >= (in_x - HALF_W) * HALF_H;
        endcase

        if (in_diamond)
        begin
            side = itp_pkg::CORNER_NONE;
        end
        else
        begin
            case (side)
                itp_pkg::CORNER_LT: col = col - 1;
                itp_pkg::CORNER_RT: row = row - 1;
                itp_pkg::CORNER_LB: row = row + 1;
                default:            col = col + 1;
            endcase
        end

        if (off_grid(col, row))
            return res;

        res.hit      = 1'b1;
        res.tile_col = col[3:0];
        res.tile_row = row[3:0];
        res.corner   = side;
        return res;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int roll;

        if (!jitter_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(input itp_pkg::result_t got);
        itp_pkg::result_t want;

        results_seen++;
        if (tile_expect.size() == 0)
        begin
            report_mismatch($sformatf("result with no point outstanding: %p", got));
            return;
        end
        want = tile_expect.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", got.hit, want.hit));
        if (got.tile_col !== want.tile_col)
            report_mismatch($sformatf("tile_col got %0d want %0d",
                                      got.tile_col, want.tile_col));
        if (got.tile_row !== want.tile_row)
            report_mismatch($sformatf("tile_row got %0d want %0d",
                                      got.tile_row, want.tile_row));
        if (got.corner !== want.corner)
            report_mismatch($sformatf("corner got %0d want %0d",
                                      got.corner, want.corner));
        if (want.hit)
            hit_count++;
        if (want.corner != itp_pkg::CORNER_NONE)
            moved_count++;
    endtask

    // Point driver. A transfer completes at an edge with valid and ready both
    // high; the prediction is made right there, with the origin then in force.
    // A new point is only presented once the previous one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_ch.valid <= 1'b0;
            pick_ch.data  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (pick_ch.valid && pick_ch.ready)
            begin
                tile_expect = {tile_expect,
                               predict_tile(pick_ch.data, scroll_x, scroll_y)};
                points_sent++;
            end
            if (!pick_ch.valid || pick_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    pick_ch.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (point_feed.size() != 0)
                begin
                    pick_ch.valid <= 1'b1;
                    pick_ch.data  <= point_feed.pop_front();
                    send_gap      <= draw_gap();
                end
                else
                begin
                    pick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result transfer is held against the oldest
    // prediction, field by field. Ready is dropped at random for stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            take_stall   <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.data);
            if (take_stall != 0)
            begin
                res_ch.ready <= 1'b0;
                take_stall   <= take_stall - 1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                take_stall   <= draw_gap();
            end
        end
    end

    // Queues one point; coordinates off the screen are clamped onto it.
    task automatic push_point(input int x, input int y);
        itp_pkg::pick_t pt;

        if (x < 0)
            x = 0;
        if (x > 4095)
            x = 4095;
        if (y < 0)
            y = 0;
        if (y > 4095)
            y = 4095;
        pt.point_x = x[11:0];
        pt.point_y = y[11:0];
        point_feed = {point_feed, pt};
    endtask

    task automatic write_reg(input logic [itp_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        if (idx == itp_pkg::CFG_ORIGIN_X)
            scroll_x = value[15:0];
        else
            scroll_y = value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_origin(input int x, input int y);
        write_reg(itp_pkg::CFG_ORIGIN_X, x);
        write_reg(itp_pkg::CFG_ORIGIN_Y, y);
        origin_count++;
    endtask

    // Holds the sender back until every point has been answered. Checked on
    // the falling edge so that the edge's own updates have all settled; the task
    // then waits out the pipeline before the origin may change.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (point_feed.size() != 0 || pick_ch.valid || tile_expect.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    // Random points for the current origin. Most land in or near the grid's
    // bounding box so that every quadrant and move is exercised; the rest are
    // spread over the whole screen to toggle every coordinate bit.
    task automatic random_points(input int count);
        int org_x;
        int org_y;

        org_x = scroll_x;
        org_y = scroll_y;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 85)
                push_point(org_x + int'($urandom_range(0, 1120)) - 560,
                           org_y + int'($urandom_range(0, 600)) - 40);
            else
                push_point(int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)));
        end
    endtask

    initial
    begin
        int org_x;
        int org_y;

        // Every input known from time zero; reset is held low at the start.
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pick_ch.valid = 1'b0;
        pick_ch.data  = '0;
        res_ch.ready  = 1'b0;
        scroll_x      = '0;
        scroll_y      = '0;
        jitter_on     = 1'b1;
        error_count   = 0;
        points_sent   = 0;
        results_seen  = 0;
        hit_count     = 0;
        moved_count   = 0;
        origin_count  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points, given as offsets from an origin that shows the grid.
        set_origin(DIR_OX, DIR_OY);
        // Cell center, a point just beside it, and the exact edge of each quadrant, which counts as inside.
        push_point(DIR_OX + 32, DIR_OY + 16);
        push_point(DIR_OX + 31, DIR_OY + 15);
        push_point(DIR_OX + 16, DIR_OY + 8);
        push_point(DIR_OX + 48, DIR_OY + 8);
        push_point(DIR_OX + 16, DIR_OY + 24);
        push_point(DIR_OX + 48, DIR_OY + 24);
        // Just outside the left-top edge of the first tile: column falls off.
        push_point(DIR_OX + 15, DIR_OY + 7);
        // Moves to each corner's neighbor that stay on the grid.
        push_point(DIR_OX + 2, DIR_OY + 34);
        push_point(DIR_OX + 62, DIR_OY + 34);
        push_point(DIR_OX + 2, DIR_OY + 30);
        push_point(DIR_OX + 62, DIR_OY + 30);
        // Right-top move from the top row: row falls off.
        push_point(DIR_OX + 62, DIR_OY + 2);
        // Left of the origin: the negative x offset is floored.
        push_point(DIR_OX - 10, DIR_OY + 40);
        // Above the origin: the cell itself is off the grid.
        push_point(DIR_OX + 40, DIR_OY - 5);
        // Right-bottom move from the last column, left-bottom move from the last row.
        push_point(DIR_OX + 7 * 64 + 60, DIR_OY + 8 * 32 + 30);
        push_point(DIR_OX - 7 * 64 + 2, DIR_OY + 8 * 32 + 30);
        // Inside the corner tile at column 15, row 15.
        push_point(DIR_OX + 32, DIR_OY + 15 * 32 + 16);
        // Extremes of the screen.
        push_point(0, 0);
        push_point(4095, 4095);
        push_point(0, 4095);
        push_point(4095, 0);
        push_point(4095, 2730);
        wait_idle();

        // Origin extremes: every point lies far off the grid.
        set_origin(-32768, -32768);
        random_points(40);
        wait_idle();
        set_origin(32767, 32767);
        random_points(40);
        wait_idle();
        set_origin(32767, -32768);
        random_points(20);
        wait_idle();

        // Origin at the screen corner: the left half of the grid is clipped.
        set_origin(0, 0);
        random_points(100);
        wait_idle();

        // Random origins, most with the grid at least partly on screen.
        // Every other setting runs without any gaps on either side.
        for (int phase = 0; phase < 10; phase++)
        begin
            jitter_on = (phase % 2) == 0;
            org_x = int'($urandom_range(0, 5000)) - 400;
            org_y = int'($urandom_range(0, 4700)) - 600;
            set_origin(org_x, org_y);
            random_points(110);
            wait_idle();
        end

        // Grid hanging off the far corner of the screen.
        jitter_on = 1'b1;
        set_origin(4095, 4095 - 300);
        random_points(50);
        wait_idle();

        // Every point is answered; give the pipeline a little more time so
        // a stray extra result would still be caught.
        repeat (20) @(posedge clk);

        $display("Sent %0d points under %0d origin settings; %0d hit a tile, %0d moved",
                 points_sent, origin_count, hit_count, moved_count);
        $display("to a neighboring tile, %0d results checked.", results_seen);
        if (error_count == 0)
        begin
            $display("iso_tile_pick_top_tb passed");
        end
        else
        begin
            $display("iso_tile_pick_top_tb failed");
        end
        $finish;
    end

endmodule
